// ===== rtl/core/ddsp_pkg.sv =====
// Shared types, constants and checksum helper for the differential-drive
// servo packet builder. No dependencies.
package ddsp_pkg;

   localparam int SPEED_LIMIT = 1023;
   localparam int SPD_W       = 10;
   localparam int PKT_LEN     = 14;
   localparam int CNT_W       = 4;
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(PKT_LEN - 1);

   // Configuration register indexes
   localparam logic [7:0] CSR_FORWARD_GAIN   = 8'd0;
   localparam logic [7:0] CSR_ROTATION_GAIN  = 8'd1;
   localparam logic [7:0] CSR_TRACK_TRIM     = 8'd2;
   localparam logic [7:0] CSR_LEFT_SERVO_ID  = 8'd3;
   localparam logic [7:0] CSR_RIGHT_SERVO_ID = 8'd4;

   // Fixed packet header bytes
   localparam logic [7:0] HDR_SYNC      = 8'hFF;
   localparam logic [7:0] HDR_BROADCAST = 8'hFE;
   localparam logic [7:0] HDR_LENGTH    = 8'h0A;
   localparam logic [7:0] HDR_INSTR     = 8'h83;
   localparam logic [7:0] HDR_ADDR      = 8'h20;
   localparam logic [7:0] HDR_DATA_LEN  = 8'h02;
   localparam logic [7:0] DIR_BIT       = 8'h04;

   localparam logic [11:0] HDR_SUM = 12'(HDR_BROADCAST) + 12'(HDR_LENGTH) + 12'(HDR_INSTR)
                                   + 12'(HDR_ADDR) + 12'(HDR_DATA_LEN);

   typedef struct packed {
      logic [23:0] forward_gain;
      logic [23:0] rotation_gain;
      logic [15:0] track_trim;
      logic [7:0]  left_servo_id;
      logic [7:0]  right_servo_id;
   } cfg_type;

   typedef struct packed {
      logic [7:0] id1;
      logic [7:0] lo1;
      logic [7:0] hi1;
      logic [7:0] id2;
      logic [7:0] lo2;
      logic [7:0] hi2;
      logic [7:0] chk;
   } pkt_type;

   function automatic logic [7:0] pkt_checksum(input logic [7:0] id1, input logic [7:0] lo1,
                                               input logic [7:0] hi1, input logic [7:0] id2,
                                               input logic [7:0] lo2, input logic [7:0] hi2);
      logic [11:0] sum;
      sum = HDR_SUM + 12'(id1) + 12'(lo1) + 12'(hi1) + 12'(id2) + 12'(lo2) + 12'(hi2);
      return ~sum[7:0];
   endfunction

endpackage

// ===== rtl/core/ddsp_mixer.sv =====
// Four-stage wheel speed mixer: gain products, mix and clamp, straightness
// product, clamp and packet field encoding. Depends on ddsp_pkg.
module ddsp_mixer
   import ddsp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic signed [15:0] linear_velocity,
   input  logic signed [15:0] angular_velocity,
   output logic               out_valid,
   input  logic               out_ready,
   output pkt_type            out_pkt
);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4     = !v4_ff || out_ready;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // Stage 1: gain products on magnitudes
   logic [15:0] lin_mag, ang_mag;
   logic [39:0] pf_in, pr_in, pf_ff, pr_ff;
   logic        negf_in, negr_in, negf_ff, negr_ff;

   always_comb begin
      lin_mag = linear_velocity[15]  ? 16'(-linear_velocity)  : 16'(linear_velocity);
      ang_mag = angular_velocity[15] ? 16'(-angular_velocity) : 16'(angular_velocity);
      pf_in   = 40'(lin_mag) * 40'(cfg.forward_gain);
      pr_in   = 40'(ang_mag) * 40'(cfg.rotation_gain);
      negf_in = linear_velocity[15]  && (cfg.forward_gain != 24'd0);
      negr_in = angular_velocity[15] && (cfg.rotation_gain != 24'd0);
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         pf_ff   <= pf_in;
         pr_ff   <= pr_in;
         negf_ff <= negf_in;
         negr_ff <= negr_in;
      end
   end

   // Stage 2: round/truncate, mix, clamp wheel one
   logic [39:0]        pf_rnd;
   logic [22:0]        mf, mr;
   logic signed [22:0] fwd, rot, w1s, diff;
   logic [22:0]        w1_mag;
   logic [SPD_W-1:0]   a1_in, a1_ff;
   logic               dir1_in, dir1_ff;
   logic [22:0]        dmag_in, dmag_ff;
   logic               dneg_in, dneg_ff;

   always_comb begin
      pf_rnd  = pf_ff + 40'h80000;
      mf      = 23'(pf_rnd[39:20]);
      mr      = 23'(pr_ff[39:20]);
      // forward term is negated after rounding
      fwd     = negf_ff ? signed'(mf) : -signed'(mf);
      rot     = negr_ff ? -signed'(mr) : signed'(mr);
      w1s     = fwd + rot;
      diff    = fwd - rot;
      w1_mag  = w1s[22] ? 23'(-w1s) : 23'(w1s);
      a1_in   = (w1_mag > 23'(SPEED_LIMIT)) ? SPD_W'(SPEED_LIMIT) : w1_mag[SPD_W-1:0];
      dir1_in = !w1s[22] && (w1s != 23'sd0);
      dmag_in = diff[22] ? 23'(-diff) : 23'(diff);
      dneg_in = diff[22];
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         a1_ff   <= a1_in;
         dir1_ff <= dir1_in;
         dmag_ff <= dmag_in;
         dneg_ff <= dneg_in;
      end
   end

   // Stage 3: straightness product for wheel two
   logic [38:0]      pd_in, pd_ff;
   logic             negd_in, negd_ff;
   logic [SPD_W-1:0] a1_s3_ff;
   logic             dir1_s3_ff;

   always_comb begin
      pd_in   = 39'(dmag_ff) * 39'(cfg.track_trim);
      negd_in = dneg_ff && (cfg.track_trim != 16'd0);
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         pd_ff      <= pd_in;
         negd_ff    <= negd_in;
         a1_s3_ff   <= a1_ff;
         dir1_s3_ff <= dir1_ff;
      end
   end

   // Stage 4: truncate and clamp wheel two, encode fields and checksum
   logic [24:0]      m2;
   logic [SPD_W-1:0] a2;
   logic             dir2;
   pkt_type          pkt_in, pkt_ff;

   always_comb begin
      m2         = pd_ff[38:14];
      a2         = (m2 > 25'(SPEED_LIMIT)) ? SPD_W'(SPEED_LIMIT) : m2[SPD_W-1:0];
      dir2       = negd_ff && (m2 != 25'd0);
      pkt_in.id1 = cfg.left_servo_id;
      pkt_in.lo1 = a1_s3_ff[7:0];
      pkt_in.hi1 = {6'd0, a1_s3_ff[SPD_W-1:8]} | (dir1_s3_ff ? DIR_BIT : 8'd0);
      pkt_in.id2 = cfg.right_servo_id;
      pkt_in.lo2 = a2[7:0];
      pkt_in.hi2 = {6'd0, a2[SPD_W-1:8]} | (dir2 ? DIR_BIT : 8'd0);
      pkt_in.chk = pkt_checksum(pkt_in.id1, pkt_in.lo1, pkt_in.hi1,
                                pkt_in.id2, pkt_in.lo2, pkt_in.hi2);
   end

   always_ff @(posedge clock) begin
      if (rdy4) pkt_ff <= pkt_in;
   end

   assign out_valid = v4_ff;
   assign out_pkt   = pkt_ff;

endmodule

// ===== rtl/core/diff_drive_servo_packet_builder.sv =====
// Top level of the differential-drive servo packet builder: configuration
// registers, mixer pipeline and packet byte serializer. Depends on ddsp_pkg, ddsp_mixer.
//
// Usage:
//   req_*  : command stream; req_tdata[15:0] = linear_velocity (signed Q4.12),
//            req_tdata[31:16] = angular_velocity (signed Q4.12).
//   rsp_*  : packet byte stream; rsp_tdata[7:0] = packet_byte, rsp_tlast
//            marks the checksum byte (fourteenth of the packet).
//   csr_*  : register writes, index 0..4 = forward_gain, rotation_gain,
//            track_trim, left_servo_id, right_servo_id. Always ready;
//            other indexes are dropped. Write only while the block is idle.
// Path: a command passes the four mixer stages, then the serializer loads the
//   packet and offers its first byte on rsp_*.
// Throughput: set by the serializer, which sends one byte per cycle while
//   rsp_tready is high; a ready next packet follows the checksum byte with no gap.
//   The mixer pipeline holds up to four further commands while a packet drains.
// Reset: clears all valid state and loads the register reset values.
// Stall: when rsp_tready is low the current byte holds; the pipeline fills
//   and then drops req_tready. Nothing is lost or repeated.
module diff_drive_servo_packet_builder
   import ddsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // command stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] linear_velocity, [31:16] angular_velocity
   // packet byte stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] packet_byte
   output logic        rsp_tlast,
   // register write port
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [23:0] csr_data
);

   // Configuration registers
   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FORWARD_GAIN:   cfg_in.forward_gain   = csr_data;
            CSR_ROTATION_GAIN:  cfg_in.rotation_gain  = csr_data;
            CSR_TRACK_TRIM:     cfg_in.track_trim     = csr_data[15:0];
            CSR_LEFT_SERVO_ID:  cfg_in.left_servo_id  = csr_data[7:0];
            CSR_RIGHT_SERVO_ID: cfg_in.right_servo_id = csr_data[7:0];
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.forward_gain   <= 24'd1009152;
         cfg_ff.rotation_gain  <= 24'd65536;
         cfg_ff.track_trim     <= 16'd16384;
         cfg_ff.left_servo_id  <= 8'd16;
         cfg_ff.right_servo_id <= 8'd18;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Mixer pipeline
   logic    mix_valid, mix_ready;
   pkt_type mix_pkt;

   ddsp_mixer u_mixer (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .in_valid         (req_tvalid),
      .in_ready         (req_tready),
      .linear_velocity  (req_tdata[15:0]),
      .angular_velocity (req_tdata[31:16]),
      .out_valid        (mix_valid),
      .out_ready        (mix_ready),
      .out_pkt          (mix_pkt)
   );

   // Serializer: hold one packet, advance one byte per accepted item
   pkt_type          pkt_ff, pkt_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             take, is_last, load;

   assign is_last   = (cnt_ff == LAST_IDX);
   assign take      = busy_ff && rsp_tready;
   assign mix_ready = !busy_ff || (take && is_last);
   assign load      = mix_valid && mix_ready;

   always_comb begin
      pkt_in  = pkt_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (load) begin
         pkt_in  = mix_pkt;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (take) begin
         if (is_last) busy_in = 1'b0;
         else         cnt_in  = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      pkt_ff <= pkt_in;
   end

   // Byte select in send order
   always_comb begin
      case (cnt_ff)
         4'd0:    rsp_tdata = HDR_SYNC;
         4'd1:    rsp_tdata = HDR_SYNC;
         4'd2:    rsp_tdata = HDR_BROADCAST;
         4'd3:    rsp_tdata = HDR_LENGTH;
         4'd4:    rsp_tdata = HDR_INSTR;
         4'd5:    rsp_tdata = HDR_ADDR;
         4'd6:    rsp_tdata = HDR_DATA_LEN;
         4'd7:    rsp_tdata = pkt_ff.id1;
         4'd8:    rsp_tdata = pkt_ff.lo1;
         4'd9:    rsp_tdata = pkt_ff.hi1;
         4'd10:   rsp_tdata = pkt_ff.id2;
         4'd11:   rsp_tdata = pkt_ff.lo2;
         4'd12:   rsp_tdata = pkt_ff.hi2;
         4'd13:   rsp_tdata = pkt_ff.chk;
         default: rsp_tdata = 8'd0;
      endcase
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = is_last;

`ifndef SYNTHESIS
   // A packet always opens with the sync byte.
   a_first_byte: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> (rsp_tdata == HDR_SYNC))
      else $error("packet does not start with sync byte");

   // The checksum byte matches the held speed and id fields.
   a_checksum: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (pkt_ff.chk == pkt_checksum(pkt_ff.id1, pkt_ff.lo1,
         pkt_ff.hi1, pkt_ff.id2, pkt_ff.lo2, pkt_ff.hi2)))
      else $error("checksum mismatch");

   // A packet never ends before its last byte is taken.
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (take && !is_last) |=> rsp_tvalid)
      else $error("packet cut short");

   // With nothing pending, the stream goes quiet after the checksum byte.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (take && is_last && !mix_valid) |=> !rsp_tvalid)
      else $error("byte stream continues without a packet");
`endif

endmodule

// ===== bench/tb_diff_drive_servo_packet_builder.sv =====
// Self-checking bench for diff_drive_servo_packet_builder: velocity commands in,
// predicted 14-byte sync-write packets checked byte by byte. Depends on ddsp_pkg.
`timescale 1ns / 1ps

module tb_diff_drive_servo_packet_builder;
   import ddsp_pkg::*;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } packet_byte_type;

   // Scoreboard: mirrors the register file, predicts the packet for every
   // accepted command and checks each delivered byte against the oldest one.
   class packet_scoreboard;
      cfg_type         regs;
      packet_byte_type expected_bytes[$];
      int              errors;

      function new();
         regs.forward_gain   = 24'd1009152;
         regs.rotation_gain  = 24'd65536;
         regs.track_trim     = 16'd16384;
         regs.left_servo_id  = 8'd16;
         regs.right_servo_id = 8'd18;
         errors = 0;
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      // Keep only the bits that each register holds; drop unknown indexes.
      function void apply_reg(logic [7:0] idx, logic [23:0] value);
         case (idx)
            CSR_FORWARD_GAIN:   regs.forward_gain   = value;
            CSR_ROTATION_GAIN:  regs.rotation_gain  = value;
            CSR_TRACK_TRIM:     regs.track_trim     = value[15:0];
            CSR_LEFT_SERVO_ID:  regs.left_servo_id  = value[7:0];
            CSR_RIGHT_SERVO_ID: regs.right_servo_id = value[7:0];
            default: ;
         endcase
      endfunction

      function longint magnitude(longint x);
         return (x < 0) ? -x : x;
      endfunction

      function longint saturate(longint x);
         if (x > SPEED_LIMIT) return SPEED_LIMIT;
         if (x < -SPEED_LIMIT) return -SPEED_LIMIT;
         return x;
      endfunction

      function void note_command(logic [15:0] lin_bits, logic [15:0] ang_bits);
         longint          lin, ang, prod, m, fwd, rot, w1, w2, a1, a2;
         logic [7:0]      pkt [PKT_LEN];
         logic [11:0]     sum;
         packet_byte_type pb;
         lin = longint'($signed(lin_bits));
         ang = longint'($signed(ang_bits));
         // forward term: negated, rounded on the magnitude, halves away from zero
         prod = lin * longint'(regs.forward_gain);
         m    = (magnitude(prod) + (longint'(1) << 19)) >> 20;
         fwd  = (prod < 0) ? m : -m;
         // rotation term: truncated toward zero
         prod = ang * longint'(regs.rotation_gain);
         m    = magnitude(prod) >> 20;
         rot  = (prod < 0) ? -m : m;
         w1   = saturate(fwd + rot);
         prod = (fwd - rot) * longint'(regs.track_trim);
         m    = magnitude(prod) >> 14;
         w2   = saturate((prod < 0) ? -m : m);
         a1   = magnitude(w1);
         a2   = magnitude(w2);
         pkt[0]  = HDR_SYNC;
         pkt[1]  = HDR_SYNC;
         pkt[2]  = HDR_BROADCAST;
         pkt[3]  = HDR_LENGTH;
         pkt[4]  = HDR_INSTR;
         pkt[5]  = HDR_ADDR;
         pkt[6]  = HDR_DATA_LEN;
         pkt[7]  = regs.left_servo_id;
         pkt[8]  = a1[7:0];
         pkt[9]  = a1[15:8] | ((w1 > 0) ? DIR_BIT : 8'h00);
         pkt[10] = regs.right_servo_id;
         pkt[11] = a2[7:0];
         pkt[12] = a2[15:8] | ((w2 < 0) ? DIR_BIT : 8'h00);
         sum = '0;
         for (int i = 2; i < 13; i++) sum += 12'(pkt[i]);
         pkt[13] = ~sum[7:0];
         for (int i = 0; i < PKT_LEN; i++) begin
            pb.data = pkt[i];
            pb.last = (i == PKT_LEN - 1);
            expected_bytes.push_back(pb);
         end
      endfunction

      function void check_byte(logic [7:0] data, logic last);
         packet_byte_type pb;
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected byte data=%h last=%b", $time, data, last);
            errors++;
            return;
         end
         pb = expected_bytes.pop_front();
         if (data !== pb.data) begin
            $display("%0t: packet byte expected %h actual %h", $time, pb.data, data);
            errors++;
         end
         if (last !== pb.last) begin
            $display("%0t: last flag expected %b actual %b", $time, pb.last, last);
            errors++;
         end
      endfunction
   endclass

   localparam int HOLDOFF_CYCLES = 300;
   localparam int PHASES         = 6;
   localparam int PHASE_ITEMS    = 53;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // [15:0] linear_velocity, [31:16] angular_velocity
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [7:0] packet_byte
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [23:0] csr_data = '0;

   packet_scoreboard sb;
   bit steady_flow     = 1'b0;   // no idling on either side while set
   bit holdoff_pending = 1'b0;   // ask the sink for one long stall

   diff_drive_servo_packet_builder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one command after a random gap and hold it until accepted. Valid is
   // lowered only at the start of a gap, so back-to-back items keep it high.
   task automatic send_command(input logic [15:0] lin, input logic [15:0] ang);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ang, lin};
      do @(posedge clock); while (!req_tready);
      sb.note_command(lin, ang);
   endtask

   // Mostly moderate speeds so the mixer stays out of saturation; the rest
   // spans the full field range.
   task automatic send_random(input int count);
      logic [15:0] lin, ang;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 75) begin
            lin = 16'($urandom_range(0, 16383)) - 16'd8192;
            ang = 16'($urandom_range(0, 16383)) - 16'd8192;
         end else begin
            lin = 16'($urandom);
            ang = 16'($urandom);
         end
         send_command(lin, ang);
      end
   endtask

   // Stop offering and wait until every predicted byte has been delivered,
   // then let the pipeline settle before any register write.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2 * PKT_LEN) @(posedge clock);
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.apply_reg(idx, value);
   endtask

   // Write all registers, with junk above the width of track_trim and the servo ids, plus one
   // write to an unused index that must be dropped.
   task automatic write_config(input cfg_type c);
      write_reg(CSR_FORWARD_GAIN, c.forward_gain);
      write_reg(CSR_ROTATION_GAIN, c.rotation_gain);
      write_reg(CSR_TRACK_TRIM, {8'($urandom), c.track_trim});
      write_reg(CSR_LEFT_SERVO_ID, {16'($urandom), c.left_servo_id});
      write_reg(CSR_RIGHT_SERVO_ID, {16'($urandom), c.right_servo_id});
      write_reg(8'($urandom_range(int'(CSR_RIGHT_SERVO_ID) + 1, 255)), 24'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Packet sink: check every accepted byte, then pick the next ready level.
   initial begin : packet_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_byte(rsp_tdata, rsp_tlast);
         if (holdoff_pending) begin
            holdoff_pending = 1'b0;
            stall_left = HOLDOFF_CYCLES;
         end else if (stall_left == 0 && $urandom_range(0, 99) < 15) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      #20_000_000;
      $display("tb_diff_drive_servo_packet_builder: errors");
      $finish;
   end

   initial begin : main_seq
      cfg_type c;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset register values: field extremes and sign corners.
      send_command(16'h0000, 16'h0000);
      send_command(16'h7FFF, 16'h0000);
      send_command(16'h8000, 16'h0000);
      send_command(16'h0000, 16'h7FFF);
      send_command(16'h0000, 16'h8000);
      send_command(16'h7FFF, 16'h7FFF);
      send_command(16'h8000, 16'h8000);
      send_command(16'h7FFF, 16'h8000);
      send_command(16'h8000, 16'h7FFF);
      send_command(16'h0001, 16'hFFFF);
      send_command(16'hFFFF, 16'h0001);
      send_command(16'h0400, 16'hFC00);
      drain();

      // Unit gains expose exact halves in the forward rounding and the
      // truncation of the rotation term; servo ids 254 and 255 pass as is.
      c.forward_gain   = 24'd256;
      c.rotation_gain  = 24'd256;
      c.track_trim     = 16'd16384;
      c.left_servo_id  = 8'd254;
      c.right_servo_id = 8'd255;
      write_config(c);
      send_command(16'd2048, 16'd2048);
      send_command(-16'sd2048, -16'sd2048);
      send_command(16'd6144, 16'd6144);
      send_command(-16'sd6144, -16'sd6144);
      send_command(16'd2047, 16'd2049);
      send_command(16'd2049, -16'sd2047);
      send_command(-16'sd2049, 16'd4096);
      send_command(16'd4096, -16'sd4096);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: c = '0;
            1: begin
               c.forward_gain   = 24'hFFFFFF;
               c.rotation_gain  = 24'hFFFFFF;
               c.track_trim     = 16'hFFFF;
               c.left_servo_id  = 8'd253;
               c.right_servo_id = 8'd0;
            end
            default: begin
               c.forward_gain  = ($urandom_range(0, 9) == 0) ? 24'($urandom)
                                                            : 24'($urandom_range(0, 24'h40000));
               c.rotation_gain = ($urandom_range(0, 9) == 0) ? 24'($urandom)
                                                            : 24'($urandom_range(0, 24'h40000));
               c.track_trim = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                              : 16'($urandom_range(8192, 24576));
               c.left_servo_id  = 8'($urandom_range(0, 253));
               c.right_servo_id = 8'($urandom_range(0, 253));
            end
         endcase
         write_config(c);
         // Phases 3 and 4 run with no random gaps; phase 4 also stalls the sink for a long
         // stretch while commands keep coming so the input side backs up.
         steady_flow = (ph == 3 || ph == 4);
         if (ph == 4) holdoff_pending = 1'b1;
         send_random(PHASE_ITEMS);
         steady_flow = 1'b0;
         drain();
      end

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_diff_drive_servo_packet_builder: clean");
      end else begin
         $display("tb_diff_drive_servo_packet_builder: errors");
      end
      $finish;
   end

endmodule
